### hw/rtl/swsp_pkg.sv
package swsp_pkg;

  // Default sizing
  localparam int SWSP_SLOTS     = 16;
  localparam int SWSP_TICK_BITS = 32;

  // Field widths fixed by the interface
  localparam int REQ_W     = 3;
  localparam int IDX_W     = 4;
  localparam int STATUS_W  = 2;
  localparam int ELAPSED_W = 32;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 3'd0,
    REQ_START = 3'd1,
    REQ_FIRST = 3'd2,
    REQ_READ  = 3'd3,
    REQ_STOP  = 3'd4,
    REQ_CLEAR = 3'd5
  } swsp_req_t;

  // Status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BUSY   = 2'd1,
    ST_NOFREE = 2'd2
  } swsp_status_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_RDMEM = 5'b00100,
    S_CALC  = 5'b01000,
    S_DONE  = 5'b10000
  } swsp_state_t;

  // Commands to the stamp store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clr_all;
  } swsp_mem_ctl_t;

endpackage

### hw/rtl/swsp_stamp_mem.sv
module swsp_stamp_mem import swsp_pkg::*; #(
  parameter int SLOTS     = SWSP_SLOTS,
  parameter int TICK_BITS = SWSP_TICK_BITS,
  localparam int AW       = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swsp_mem_ctl_t        ctl,
  input  logic [AW-1:0]        wr_addr,
  input  logic [TICK_BITS-1:0] wr_data,
  input  logic [AW-1:0]        rd_addr,
  output logic [TICK_BITS-1:0] rd_stamp
);

  logic [TICK_BITS-1:0] mem [SLOTS];
  logic [SLOTS-1:0]     valid_r;
  logic [TICK_BITS-1:0] rd_data_r;
  logic                 rd_hit_r;

  // Entry valid bits: an entry never written since reset or clear reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (ctl.clr_all) begin
        valid_r <= '0;
      end else if (ctl.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_hit_r <= valid_r[rd_addr];
      end
    end
  end

  // Stamp array, one write and one registered read port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_stamp = rd_hit_r ? rd_data_r : '0;

endmodule

### hw/rtl/stopwatch_slot_pool_unit.sv
// Channel  Direction  Ports                                         Handshake
// in       input      in_req_type, in_slot_index                    in_valid / in_ready
// out      output     out_status, out_slot_out, out_elapsed_ticks   out_valid / out_ready
//
// One request at a time. Tick, start named, clear all, unknown codes and read or stop
// of an index at or above SLOTS go straight to the done state; read and stop of a slot
// pass through a stamp read, then a subtract. Start first free tests the busy slots one
// per cycle, lowest first, until it finds a free one or reaches the last slot.
// Reset (rst_n low, synchronous) zeroes the tick counter and frees all slots.
// A result held in the output register while out_ready is low keeps the next
// request in its final state; a new beat is taken as soon as the sequencer idles.
module stopwatch_slot_pool_unit import swsp_pkg::*; #(
  parameter int SLOTS     = SWSP_SLOTS,
  parameter int TICK_BITS = SWSP_TICK_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic [IDX_W-1:0]     in_slot_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [IDX_W-1:0]     out_slot_out,
  output logic [ELAPSED_W-1:0] out_elapsed_ticks
);

  localparam int AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CMPW = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

  swsp_state_t           state_r, state_nxt;
  swsp_req_t             req_r, req_nxt;
  logic [AW-1:0]         addr_r, addr_nxt;
  logic [AW-1:0]         scan_r, scan_nxt;
  logic [TICK_BITS-1:0]  tick_r, tick_nxt;
  logic [SLOTS-1:0]      busy_r, busy_nxt;
  swsp_status_t          res_status_r, res_status_nxt;
  logic [IDX_W-1:0]      res_slot_r, res_slot_nxt;
  logic [ELAPSED_W-1:0]  res_elapsed_r, res_elapsed_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [IDX_W-1:0]      out_slot_r, out_slot_nxt;
  logic [ELAPSED_W-1:0]  out_elapsed_r, out_elapsed_nxt;

  logic                  accept;
  logic [AW-1:0]         addr_in;
  logic                  in_range;
  swsp_mem_ctl_t         mem_ctl;
  logic [AW-1:0]         wr_addr;
  logic [TICK_BITS-1:0]  stamp;
  logic                  alu_sub;
  logic [TICK_BITS-1:0]  alu_b;
  logic [TICK_BITS-1:0]  alu_res;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign addr_in  = AW'(in_slot_index);
  assign in_range = CMPW'(in_slot_index) < CMPW'(SLOTS);

  // Shared adder: tick increment or elapsed subtract
  assign alu_sub = (state_r == S_CALC);
  assign alu_b   = alu_sub ? stamp : TICK_BITS'(1);
  assign alu_res = tick_r + (alu_sub ? ~alu_b : alu_b) + TICK_BITS'(alu_sub);

  swsp_stamp_mem #(
    .SLOTS     (SLOTS),
    .TICK_BITS (TICK_BITS)
  ) u_stamp_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mem_ctl),
    .wr_addr  (wr_addr),
    .wr_data  (tick_r),
    .rd_addr  (addr_r),
    .rd_stamp (stamp)
  );

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    addr_nxt        = addr_r;
    scan_nxt        = scan_r;
    tick_nxt        = tick_r;
    busy_nxt        = busy_r;
    res_status_nxt  = res_status_r;
    res_slot_nxt    = res_slot_r;
    res_elapsed_nxt = res_elapsed_r;
    out_valid_nxt   = out_valid_r & ~out_ready;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_elapsed_nxt = out_elapsed_r;
    mem_ctl         = '0;
    wr_addr         = addr_in;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt         = swsp_req_t'(in_req_type);
          addr_nxt        = addr_in;
          res_status_nxt  = ST_OK;
          res_slot_nxt    = '0;
          res_elapsed_nxt = '0;
          state_nxt       = S_DONE;
          case (in_req_type)
            REQ_TICK: begin
              tick_nxt = alu_res;
            end
            REQ_START: begin
              res_slot_nxt = in_slot_index;
              if (!in_range) begin
                res_status_nxt = ST_NOFREE;
              end else if (busy_r[addr_in]) begin
                res_status_nxt = ST_BUSY;
              end else begin
                mem_ctl.wr_en     = 1'b1;
                busy_nxt[addr_in] = 1'b1;
              end
            end
            REQ_FIRST: begin
              scan_nxt  = '0;
              state_nxt = S_SCAN;
            end
            REQ_READ, REQ_STOP: begin
              res_slot_nxt = in_slot_index;
              if (in_range) begin
                state_nxt = S_RDMEM;
              end
            end
            REQ_CLEAR: begin
              mem_ctl.clr_all = 1'b1;
              busy_nxt        = '0;
            end
            default: ;
          endcase
        end
      end
      // One busy bit per cycle, lowest first
      S_SCAN: begin
        wr_addr = scan_r;
        if (!busy_r[scan_r]) begin
          mem_ctl.wr_en    = 1'b1;
          busy_nxt[scan_r] = 1'b1;
          res_slot_nxt     = IDX_W'(scan_r);
          state_nxt        = S_DONE;
        end else if (scan_r == LAST_SLOT) begin
          res_status_nxt = ST_NOFREE;
          state_nxt      = S_DONE;
        end else begin
          scan_nxt = scan_r + AW'(1);
        end
      end
      S_RDMEM: begin
        mem_ctl.rd_en = 1'b1;
        state_nxt     = S_CALC;
      end
      S_CALC: begin
        res_elapsed_nxt = ELAPSED_W'(alu_res);
        if (req_r == REQ_STOP) begin
          busy_nxt[addr_r] = 1'b0;
        end
        state_nxt = S_DONE;
      end
      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_slot_nxt    = res_slot_r;
          out_elapsed_nxt = res_elapsed_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    addr_r        <= addr_nxt;
    scan_r        <= scan_nxt;
    res_status_r  <= res_status_nxt;
    res_slot_r    <= res_slot_nxt;
    res_elapsed_r <= res_elapsed_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_elapsed_r <= out_elapsed_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot_out      = out_slot_r;
  assign out_elapsed_ticks = out_elapsed_r;

endmodule

### bench/tb_stopwatch_slot_pool_unit.sv
module tb_stopwatch_slot_pool_unit;
  import swsp_pkg::*;

  // Codes outside the request set; the block must ignore them
  localparam logic [REQ_W-1:0] REQ_BAD6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_BAD7 = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [IDX_W-1:0] idx;
  } pool_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [IDX_W-1:0]     slot;
    logic [ELAPSED_W-1:0] elapsed;
  } pool_resp_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [REQ_W-1:0]     in_req_type;
  logic [IDX_W-1:0]     in_slot_index;
  logic                 out_valid;
  logic                 out_ready;
  logic [STATUS_W-1:0]  out_status;
  logic [IDX_W-1:0]     out_slot_out;
  logic [ELAPSED_W-1:0] out_elapsed_ticks;

  stopwatch_slot_pool_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_slot_index     (in_slot_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_slot_out      (out_slot_out),
    .out_elapsed_ticks (out_elapsed_ticks)
  );

  always #5 clk = ~clk;

  // Shadow copy of the pool
  logic [SWSP_TICK_BITS-1:0] tick_now;
  logic [SWSP_TICK_BITS-1:0] stamp_mem [SWSP_SLOTS];
  logic                      slot_live [SWSP_SLOTS];

  pool_req_t  pending_beats[$];
  pool_resp_t expected_results[$];

  int total_beats;
  int beats_taken;
  int beats_checked;
  int err_count;
  int req_tally [8];
  int busy_seen;
  int full_seen;
  logic [ELAPSED_W-1:0] max_elapsed;
  logic in_beat_taken;
  logic hold_off;
  int send_gap;
  int send_calm;
  int recv_gap;
  int recv_calm;
  pool_resp_t want;
  pool_resp_t got;

  // Expected result of one request; updates the shadow pool
  function automatic pool_resp_t predict_pool(pool_req_t r);
    pool_resp_t resp;
    int s;
    resp = '0;
    resp.status = ST_OK;
    case (r.req)
      REQ_TICK: tick_now = tick_now + 1'b1;
      REQ_START: begin
        resp.slot = r.idx;
        if (r.idx >= SWSP_SLOTS) begin
          resp.status = ST_NOFREE;
        end else if (slot_live[r.idx]) begin
          resp.status = ST_BUSY;
        end else begin
          stamp_mem[r.idx] = tick_now;
          slot_live[r.idx] = 1'b1;
        end
      end
      REQ_FIRST: begin
        s = 0;
        while (s < SWSP_SLOTS && slot_live[s]) s++;
        if (s < SWSP_SLOTS) begin
          stamp_mem[s] = tick_now;
          slot_live[s] = 1'b1;
          resp.slot = IDX_W'(s);
        end else begin
          resp.status = ST_NOFREE;
        end
      end
      REQ_READ, REQ_STOP: begin
        resp.slot = r.idx;
        if (r.idx < SWSP_SLOTS) begin
          resp.elapsed = ELAPSED_W'(tick_now - stamp_mem[r.idx]);
          if (r.req == REQ_STOP) slot_live[r.idx] = 1'b0;
        end
      end
      REQ_CLEAR: begin
        for (s = 0; s < SWSP_SLOTS; s++) begin
          stamp_mem[s] = '0;
          slot_live[s] = 1'b0;
        end
      end
      default: ;
    endcase
    return resp;
  endfunction

  // Idle length: mostly none, some short, a few long, with calm stretches
  task automatic idle_len(inout int calm, output int len);
    int roll;
    roll = $urandom_range(0, 99);
    len = 0;
    if (calm > 0) begin
      calm--;
    end else if (roll < 3) begin
      calm = $urandom_range(15, 60);
    end else if (roll >= 60 && roll < 92) begin
      len = $urandom_range(1, 3);
    end else if (roll >= 92) begin
      len = $urandom_range(8, 30);
    end
  endtask

  task automatic add_beat(input logic [REQ_W-1:0] r, input logic [IDX_W-1:0] i);
    pool_req_t b;
    b.req = r;
    b.idx = i;
    pending_beats.push_back(b);
  endtask

  // Reset and initial drive
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_slot_index = '0;
    out_ready = 1'b0;
    hold_off = 1'b0;
    in_beat_taken = 1'b0;
    send_gap = 0;
    send_calm = 0;
    recv_gap = 0;
    recv_calm = 0;
    tick_now = '0;
    for (int s = 0; s < SWSP_SLOTS; s++) begin
      stamp_mem[s] = '0;
      slot_live[s] = 1'b0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  // Sender: next beat from the pending queue, holding until taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_beat_taken) begin
        // hold payload
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        in_valid <= 1'b1;
        in_req_type <= pending_beats[0].req;
        in_slot_index <= pending_beats[0].idx;
        void'(pending_beats.pop_front());
        idle_len(send_calm, send_gap);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus the long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !hold_off;
        idle_len(recv_calm, recv_gap);
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering
  initial begin
    while (beats_taken < 150) @(posedge clk);
    hold_off = 1'b1;
    repeat (80) @(posedge clk);
    hold_off = 1'b0;
    while (beats_taken < 400) @(posedge clk);
    hold_off = 1'b1;
    repeat (120) @(posedge clk);
    hold_off = 1'b0;
  end

  // Monitor: check result beats, predict on accepted input beats
  always @(posedge clk) begin
    in_beat_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.status = out_status;
        got.slot = out_slot_out;
        got.elapsed = out_elapsed_ticks;
        if (expected_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result beat: status %0d slot %0d elapsed %0d",
                     got.status, got.slot, got.elapsed);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            err_count++;
            if (err_count <= 10)
              $display({"result %0d mismatch: status exp %0d got %0d, slot exp %0d got %0d,",
                        " elapsed exp %0d got %0d"}, beats_checked, want.status, got.status,
                       want.slot, got.slot, want.elapsed, got.elapsed);
          end
          if (want.status == ST_BUSY) busy_seen++;
          if (want.status == ST_NOFREE) full_seen++;
          if (want.elapsed > max_elapsed) max_elapsed = want.elapsed;
          beats_checked++;
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_pool('{req: in_req_type, idx: in_slot_index}));
        req_tally[in_req_type]++;
        beats_taken++;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int known;
    int roll;
    int n;
    beats_taken = 0;
    beats_checked = 0;
    err_count = 0;
    busy_seen = 0;
    full_seen = 0;
    max_elapsed = '0;
    for (int k = 0; k < 8; k++) req_tally[k] = 0;

    // Directed: field extremes, every request, free-slot reads, busy start
    add_beat(REQ_TICK, 4'd0);
    add_beat(REQ_TICK, 4'd15);
    add_beat(REQ_START, 4'd0);
    add_beat(REQ_START, 4'd0);
    add_beat(REQ_FIRST, 4'd0);
    add_beat(REQ_START, 4'd15);
    add_beat(REQ_TICK, 4'd7);
    add_beat(REQ_TICK, 4'd8);
    add_beat(REQ_READ, 4'd0);
    add_beat(REQ_READ, 4'd7);
    add_beat(REQ_STOP, 4'd0);
    add_beat(REQ_READ, 4'd0);
    add_beat(REQ_STOP, 4'd1);
    add_beat(REQ_FIRST, 4'd15);
    add_beat(REQ_BAD6, 4'd5);
    add_beat(REQ_BAD7, 4'd10);
    add_beat(REQ_CLEAR, 4'd10);
    add_beat(REQ_READ, 4'd15);
    add_beat(REQ_FIRST, 4'd3);
    known = 17;

    // Random: tick bursts, fill runs to reach a full pool, single requests and unknown codes
    while (known < 550) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        n = $urandom_range(2, 25);
        repeat (n) add_beat(REQ_TICK, IDX_W'($urandom_range(0, 15)));
        known += n;
      end else if (roll < 15) begin
        n = $urandom_range(4, 17);
        repeat (n) add_beat(REQ_FIRST, IDX_W'($urandom_range(0, 15)));
        known += n;
      end else if (roll < 93) begin
        roll = $urandom_range(0, 99);
        if (roll < 25) add_beat(REQ_TICK, IDX_W'($urandom_range(0, 15)));
        else if (roll < 40) add_beat(REQ_START, IDX_W'($urandom_range(0, 15)));
        else if (roll < 55) add_beat(REQ_FIRST, IDX_W'($urandom_range(0, 15)));
        else if (roll < 75) add_beat(REQ_READ, IDX_W'($urandom_range(0, 15)));
        else if (roll < 95) add_beat(REQ_STOP, IDX_W'($urandom_range(0, 15)));
        else add_beat(REQ_CLEAR, IDX_W'($urandom_range(0, 15)));
        known++;
      end else begin
        add_beat($urandom_range(0, 1) ? REQ_BAD7 : REQ_BAD6, IDX_W'($urandom_range(0, 15)));
      end
    end
    total_beats = pending_beats.size();

    while (beats_taken < total_beats) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d requests: tick %0d, start %0d, first-free %0d, read %0d, stop %0d,",
             beats_taken, req_tally[REQ_TICK], req_tally[REQ_START], req_tally[REQ_FIRST],
             req_tally[REQ_READ], req_tally[REQ_STOP]);
    $display("clear %0d, unknown %0d; busy refusals %0d, pool-full refusals %0d, max elapsed %0d",
             req_tally[REQ_CLEAR], req_tally[REQ_BAD6] + req_tally[REQ_BAD7], busy_seen,
             full_seen, max_elapsed);
    if (err_count == 0) begin
      $display("tb_stopwatch_slot_pool_unit: done, clean");
    end else begin
      $display("%0d mismatches", err_count);
      $display("tb_stopwatch_slot_pool_unit: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("tb_stopwatch_slot_pool_unit: done, errors");
    $finish;
  end

endmodule
